FILE: src/qau_pkg.sv
// ----------------------------------------------------------------------------
// qau_pkg
// Shared types and constants for the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
package qau_pkg;

    localparam int FRAC_BITS_DEF  = 14;
    localparam int COMP_WIDTH_DEF = 16;
    localparam int CW             = COMP_WIDTH_DEF;
    localparam int MW             = CW + 1;

    localparam logic [2:0] OP_PRODUCT   = 3'd0;
    localparam logic [2:0] OP_VECTOR    = 3'd1;
    localparam logic [2:0] OP_CONJUGATE = 3'd2;
    localparam logic [2:0] OP_NORMALIZE = 3'd3;
    localparam logic [2:0] OP_LENGTH    = 3'd4;

    typedef struct packed {
        logic [2:0]           op;
        logic signed [CW-1:0] a_x;
        logic signed [CW-1:0] a_y;
        logic signed [CW-1:0] a_z;
        logic signed [CW-1:0] a_w;
        logic signed [CW-1:0] b_x;
        logic signed [CW-1:0] b_y;
        logic signed [CW-1:0] b_z;
        logic signed [CW-1:0] b_w;
    } in_item_t;

    typedef struct packed {
        logic signed [CW-1:0] r_x;
        logic signed [CW-1:0] r_y;
        logic signed [CW-1:0] r_z;
        logic signed [CW-1:0] r_w;
        logic [MW-1:0]        magnitude;
        logic                 zero_length;
        logic                 saturated;
    } out_item_t;

endpackage

FILE: src/qau_sqrt_stage.sv
// ----------------------------------------------------------------------------
// qau_sqrt_stage
// One root bit of a restoring integer square root, registered.
// ----------------------------------------------------------------------------
module qau_sqrt_stage #(
    parameter int SW  = 36,
    parameter int POS = 0
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [SW-1:0] rem_in,
    input  logic [SW-1:0] res_in,
    output logic [SW-1:0] rem_out,
    output logic [SW-1:0] res_out
);
    logic [SW-1:0] rem_reg, res_reg, rem_next, res_next, bit_v, trial;

    always_comb begin
        bit_v = '0;
        bit_v[2*POS] = 1'b1;
        trial = res_in + bit_v;
        if (rem_in >= trial) begin
            rem_next = rem_in - trial;
            res_next = (res_in >> 1) + bit_v;
        end else begin
            rem_next = rem_in;
            res_next = res_in >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            res_reg <= res_next;
        end
    end

    assign rem_out = rem_reg;
    assign res_out = res_reg;
endmodule

FILE: src/qau_div_stage.sv
// ----------------------------------------------------------------------------
// qau_div_stage
// One quotient bit of a restoring unsigned divider, registered.
// ----------------------------------------------------------------------------
module qau_div_stage #(
    parameter int NW  = 32,
    parameter int DW  = 17,
    parameter int POS = 0
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [NW-1:0] num_in,
    input  logic [DW-1:0] den,
    input  logic [NW-1:0] q_in,
    input  logic [DW:0]   part_in,
    output logic [NW-1:0] q_out,
    output logic [DW:0]   part_out
);
    logic [DW+1:0] sh;
    logic [DW:0]   part_reg, part_next;
    logic [NW-1:0] q_reg, q_next;

    always_comb begin
        sh = {part_in, num_in[POS]};
        q_next = q_in;
        if (sh >= {2'b00, den}) begin
            part_next = (DW+1)'(sh - {2'b00, den});
            q_next[POS] = 1'b1;
        end else begin
            part_next = sh[DW:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            part_reg <= part_next;
            q_reg    <= q_next;
        end
    end

    assign q_out = q_reg;
    assign part_out = part_reg;
endmodule

FILE: src/quaternion_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// Pipelined quaternion product (also with B's w taken as zero), conjugate,
// length and normalize.
// Usage:
//   Input channel s_valid/s_ready/s_data carries op plus quaternions A and B.
//   Result channel m_valid/m_ready/m_data carries r_x..r_w, magnitude and the
//   zero_length and saturated flags. One transaction in gives one out.
//   Throughput: one transaction per cycle while the output is not stalled.
//   The pipe has one stage of multiplies, one of sums, one per square-root
//   result bit (component width + 1 stages), one rounding stage, one per
//   quotient bit of the normalize divider (component width + FRAC_BITS
//   stages) and a final clip stage. The divider chain is the longest part
//   of the pipe.
//   All stages advance together: when m_ready is low and the output register
//   is full, the whole pipe holds, so nothing is dropped or repeated.
//   s_ready is high whenever the pipe can advance.
//   Reset (aresetn low, synchronous) clears all valid bits; data registers
//   are not reset.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit #(
    parameter int FRAC_BITS  = qau_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  qau_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output qau_pkg::out_item_t m_data
);
    localparam int CW  = qau_pkg::CW;
    localparam int PW  = 2*CW + 2;          // sum of four products
    localparam int SW  = 2*CW + 2;          // sum of squares
    localparam int NSQ = (SW + 1) / 2;      // square root stages
    localparam int MW  = qau_pkg::MW;
    localparam int NW  = CW + FRAC_BITS;    // dividend width
    localparam int DEPTH = 2 + NSQ + 1 + NW + 1;

    logic [DEPTH-1:0] vld_reg;
    logic             adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (adv) vld_reg <= {vld_reg[DEPTH-2:0], s_valid};
    end

    // Stage 1: products and squares.
    logic signed [2*CW:0] p_reg [16];
    logic [2*CW-1:0]      sq_reg [4];
    logic signed [CW-1:0] a_reg [4];
    logic [2:0]           op1_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            logic signed [CW-1:0] ax, ay, az, aw, bx, by, bz, bw;
            ax = s_data.a_x; ay = s_data.a_y; az = s_data.a_z; aw = s_data.a_w;
            bx = s_data.b_x; by = s_data.b_y; bz = s_data.b_z;
            bw = (s_data.op == qau_pkg::OP_VECTOR) ? '0 : s_data.b_w;
            p_reg[0]  <= ax*bw;  p_reg[1]  <= aw*bx;  p_reg[2]  <= ay*bz;
            p_reg[3]  <= -(az*by);
            p_reg[4]  <= ay*bw;  p_reg[5]  <= aw*by;  p_reg[6]  <= az*bx;
            p_reg[7]  <= -(ax*bz);
            p_reg[8]  <= az*bw;  p_reg[9]  <= aw*bz;  p_reg[10] <= ax*by;
            p_reg[11] <= -(ay*bx);
            p_reg[12] <= aw*bw;  p_reg[13] <= -(ax*bx); p_reg[14] <= -(ay*by);
            p_reg[15] <= -(az*bz);
            sq_reg[0] <= (2*CW)'(ax*ax); sq_reg[1] <= (2*CW)'(ay*ay);
            sq_reg[2] <= (2*CW)'(az*az); sq_reg[3] <= (2*CW)'(aw*aw);
            a_reg[0] <= ax; a_reg[1] <= ay; a_reg[2] <= az; a_reg[3] <= aw;
            op1_reg <= s_data.op;
        end
    end

    // Stage 2: sums, rounding and clipping of products, conjugate, sum of squares.
    logic signed [CW-1:0] pr_reg [4];
    logic                 psat_reg;
    logic [SW-1:0]        s_reg;
    logic signed [CW-1:0] a2_reg [4];
    logic [2:0]           op2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            logic signed [PW-1:0] sum, q;
            logic signed [CW:0]   neg;
            logic                 sat;
            sat = 1'b0;
            for (int i = 0; i < 4; i++) begin
                sum = PW'(p_reg[4*i]) + PW'(p_reg[4*i+1]) + PW'(p_reg[4*i+2])
                    + PW'(p_reg[4*i+3]) + (PW'(1) <<< (FRAC_BITS-1));
                q = sum >>> FRAC_BITS;
                if (op1_reg == qau_pkg::OP_PRODUCT || op1_reg == qau_pkg::OP_VECTOR) begin
                    if (q > PW'((2**(CW-1))-1)) begin
                        pr_reg[i] <= {1'b0, {(CW-1){1'b1}}}; sat = 1'b1;
                    end else if (q < -PW'(2**(CW-1))) begin
                        pr_reg[i] <= {1'b1, {(CW-1){1'b0}}}; sat = 1'b1;
                    end else pr_reg[i] <= CW'(q);
                end else if (op1_reg == qau_pkg::OP_CONJUGATE) begin
                    if (i == 3) pr_reg[i] <= a_reg[3];
                    else begin
                        neg = -(CW+1)'(a_reg[i]);
                        if (neg > (CW+1)'((2**(CW-1))-1)) begin
                            pr_reg[i] <= {1'b0, {(CW-1){1'b1}}}; sat = 1'b1;
                        end else pr_reg[i] <= CW'(neg);
                    end
                end else pr_reg[i] <= '0;
            end
            psat_reg <= sat;
            s_reg <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]) + SW'(sq_reg[3]);
            a2_reg <= a_reg;
            op2_reg <= op1_reg;
        end
    end

    // Square root chain, with side data carried alongside.
    logic [SW-1:0] rem_w [NSQ+1];
    logic [SW-1:0] res_w [NSQ+1];
    typedef struct packed {
        logic [2:0]           op;
        logic signed [CW-1:0] r0, r1, r2, r3;
        logic                 sat;
        logic signed [CW-1:0] a0, a1, a2, a3;
    } side_t;
    side_t side_reg [NSQ];
    side_t side_c [NSQ+1];
    side_t side_in;
    assign side_in = '{op: op2_reg, r0: pr_reg[0], r1: pr_reg[1], r2: pr_reg[2],
                       r3: pr_reg[3], sat: psat_reg, a0: a2_reg[0], a1: a2_reg[1],
                       a2: a2_reg[2], a3: a2_reg[3]};
    assign side_c[0] = side_in;
    assign rem_w[0] = s_reg;
    assign res_w[0] = '0;

    for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
        qau_sqrt_stage #(.SW(SW), .POS(NSQ-1-g)) u_sq (
            .aclk(aclk), .en(adv), .rem_in(rem_w[g]), .res_in(res_w[g]),
            .rem_out(rem_w[g+1]), .res_out(res_w[g+1]));
        always_ff @(posedge aclk) begin
            if (adv) side_reg[g] <= side_c[g];
        end
        assign side_c[g+1] = side_reg[g];
    end

    // Rounding stage for the root; set up the divider.
    logic [MW-1:0] mag_reg;
    side_t         side3_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            logic [SW-1:0] rs, rm;
            rs = res_w[NSQ];
            rm = rem_w[NSQ];
            if (rm > rs) rs = rs + SW'(1);
            mag_reg <= MW'(rs);
            side3_reg <= side_reg[NSQ-1];
        end
    end

    // Divider chain, four lanes.
    logic [NW-1:0] num_w [4][NW+1];
    logic [NW-1:0] q_w   [4][NW+1];
    logic [MW:0]   pt_w  [4][NW+1];
    logic [MW-1:0] den_reg [NW];
    side_t         side4_reg [NW];
    logic [MW-1:0] magd_reg [NW];
    logic [MW-1:0] den_c [NW+1];
    side_t         side4_c [NW+1];
    logic [MW-1:0] magd_c [NW+1];
    logic [MW-1:0] den0;
    assign den0 = (mag_reg == '0) ? MW'(1) : mag_reg;
    assign den_c[0]   = den0;
    assign side4_c[0] = side3_reg;
    assign magd_c[0]  = mag_reg;

    for (genvar l = 0; l < 4; l++) begin : g_lane
        logic signed [CW-1:0] av;
        logic [CW:0]          mabs;
        assign av = (l == 0) ? side3_reg.a0 : (l == 1) ? side3_reg.a1 :
                    (l == 2) ? side3_reg.a2 : side3_reg.a3;
        assign mabs = av[CW-1] ? -(CW+1)'(av) : (CW+1)'(av);
        assign num_w[l][0] = NW'({mabs, {FRAC_BITS{1'b0}}}) + NW'(mag_reg >> 1);
        assign q_w[l][0] = '0;
        assign pt_w[l][0] = '0;
        for (genvar k = 0; k < NW; k++) begin : g_bit
            logic [NW-1:0] nreg;
            qau_div_stage #(.NW(NW), .DW(MW), .POS(NW-1-k)) u_dv (
                .aclk(aclk), .en(adv), .num_in(num_w[l][k]),
                .den(den_c[k]), .q_in(q_w[l][k]),
                .part_in(pt_w[l][k]), .q_out(q_w[l][k+1]), .part_out(pt_w[l][k+1]));
            always_ff @(posedge aclk) begin
                if (adv) nreg <= num_w[l][k];
            end
            assign num_w[l][k+1] = nreg;
        end
    end

    for (genvar k = 0; k < NW; k++) begin : g_dside
        always_ff @(posedge aclk) begin
            if (adv) begin
                den_reg[k]   <= den_c[k];
                side4_reg[k] <= side4_c[k];
                magd_reg[k]  <= magd_c[k];
            end
        end
        assign den_c[k+1]   = den_reg[k];
        assign side4_c[k+1] = side4_reg[k];
        assign magd_c[k+1]  = magd_reg[k];
    end

    // Final stage: sign, clip, select result.
    qau_pkg::out_item_t out_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            side_t                sd;
            logic [MW-1:0]        mg;
            logic signed [NW:0]   v;
            logic signed [CW-1:0] rr [4];
            logic                 sat, zl, neg;
            sd = side4_reg[NW-1];
            mg = magd_reg[NW-1];
            sat = 1'b0; zl = 1'b0;
            rr[0] = sd.r0; rr[1] = sd.r1; rr[2] = sd.r2; rr[3] = sd.r3;
            if (sd.op == qau_pkg::OP_NORMALIZE) begin
                if (mg == '0) begin
                    zl = 1'b1;
                    for (int i = 0; i < 4; i++) rr[i] = '0;
                end else begin
                    for (int i = 0; i < 4; i++) begin
                        neg = (i == 0) ? sd.a0[CW-1] : (i == 1) ? sd.a1[CW-1] :
                              (i == 2) ? sd.a2[CW-1] : sd.a3[CW-1];
                        v = neg ? -(NW+1)'(q_w[i][NW]) : (NW+1)'(q_w[i][NW]);
                        if (v > (NW+1)'((2**(CW-1))-1)) begin
                            rr[i] = {1'b0, {(CW-1){1'b1}}}; sat = 1'b1;
                        end else if (v < -(NW+1)'(2**(CW-1))) begin
                            rr[i] = {1'b1, {(CW-1){1'b0}}}; sat = 1'b1;
                        end else rr[i] = CW'(v);
                    end
                end
            end else if (sd.op != qau_pkg::OP_LENGTH) begin
                sat = sd.sat;
            end
            out_reg.r_x <= rr[0]; out_reg.r_y <= rr[1];
            out_reg.r_z <= rr[2]; out_reg.r_w <= rr[3];
            out_reg.magnitude <= (sd.op == qau_pkg::OP_NORMALIZE ||
                                  sd.op == qau_pkg::OP_LENGTH) ? mg : '0;
            out_reg.zero_length <= zl;
            out_reg.saturated <= sat;
        end
    end
    assign m_data = out_reg;

endmodule

FILE: src/qau_checker.sv
// ----------------------------------------------------------------------------
// qau_checker
// Port-level assertions for the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
module qau_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input qau_pkg::out_item_t m_data
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("ready low with empty output");
    a_zl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.zero_length |-> m_data.magnitude == '0 && m_data.r_x == '0)
        else $error("zero length with nonzero result");
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("valid after reset");
endmodule

bind quaternion_arithmetic_unit qau_checker u_qau_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data));

FILE: dv/quaternion_arithmetic_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit_checker
// Watches both channels of the quaternion unit, predicts each result from the
// accepted transaction and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  qau_pkg::in_item_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  qau_pkg::out_item_t m_data,
    output int                 fail_count,
    output int                 pending_count
);

    localparam int FB = qau_pkg::FRAC_BITS_DEF;
    localparam int CW = qau_pkg::CW;
    localparam int MW = qau_pkg::MW;

    qau_pkg::out_item_t quat_results_due[$];

    function automatic logic signed [CW-1:0] clamp_comp(input longint v, inout bit sat);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (CW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            sat = 1'b1;
            return hi[CW-1:0];
        end
        if (v < lo) begin
            sat = 1'b1;
            return lo[CW-1:0];
        end
        return v[CW-1:0];
    endfunction

    // Exact sum, divide by 2^FB rounding half up, then clamp.
    function automatic logic signed [CW-1:0] round_products(input longint p0, input longint p1,
                                                            input longint p2, input longint p3,
                                                            inout bit sat);
        longint s;
        s = p0 + p1 + p2 + p3 + (64'sd1 <<< (FB - 1));
        return clamp_comp(s >>> FB, sat);
    endfunction

    function automatic longint unsigned root_nearest(input longint unsigned s);
        longint unsigned r;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lo = 0;
        hi = 64'd4294967295;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid <= s) lo = mid;
            else hi = mid - 1;
        end
        r = lo;
        if (s - r * r > r) r++;
        return r;
    endfunction

    function automatic qau_pkg::out_item_t predict_quat(input qau_pkg::in_item_t t);
        qau_pkg::out_item_t res;
        bit                 sat;
        longint             ax, ay, az, aw, bx, by, bz, bw;
        longint             a[4];
        longint unsigned    sumsq, len, m, q;
        res = '0;
        sat = 1'b0;
        ax = t.a_x; ay = t.a_y; az = t.a_z; aw = t.a_w;
        bx = t.b_x; by = t.b_y; bz = t.b_z; bw = t.b_w;
        if (t.op == qau_pkg::OP_VECTOR) bw = 0;
        case (t.op) inside
            qau_pkg::OP_PRODUCT, qau_pkg::OP_VECTOR: begin
                res.r_x = round_products(ax*bw, aw*bx, ay*bz, -(az*by), sat);
                res.r_y = round_products(ay*bw, aw*by, az*bx, -(ax*bz), sat);
                res.r_z = round_products(az*bw, aw*bz, ax*by, -(ay*bx), sat);
                res.r_w = round_products(aw*bw, -(ax*bx), -(ay*by), -(az*bz), sat);
            end
            qau_pkg::OP_CONJUGATE: begin
                res.r_x = clamp_comp(-ax, sat);
                res.r_y = clamp_comp(-ay, sat);
                res.r_z = clamp_comp(-az, sat);
                res.r_w = t.a_w;
            end
            qau_pkg::OP_NORMALIZE, qau_pkg::OP_LENGTH: begin
                sumsq = ax*ax + ay*ay + az*az + aw*aw;
                len = root_nearest(sumsq);
                res.magnitude = len[MW-1:0];
                if (t.op == qau_pkg::OP_NORMALIZE) begin
                    if (len == 0) begin
                        res.zero_length = 1'b1;
                    end else begin
                        a = '{ax, ay, az, aw};
                        for (int i = 0; i < 4; i++) begin
                            m = (a[i] < 0) ? -a[i] : a[i];
                            q = ((m << FB) + (len >> 1)) / len;
                            a[i] = (a[i] < 0) ? -longint'(q) : longint'(q);
                        end
                        res.r_x = clamp_comp(a[0], sat);
                        res.r_y = clamp_comp(a[1], sat);
                        res.r_z = clamp_comp(a[2], sat);
                        res.r_w = clamp_comp(a[3], sat);
                    end
                end
            end
            default: ;
        endcase
        res.saturated = sat;
        return res;
    endfunction

    assign pending_count = quat_results_due.size();

    always @(posedge aclk) begin
        qau_pkg::out_item_t want;
        if (!aresetn) begin
            quat_results_due.delete();
            fail_count <= 0;
        end else begin
            if (s_valid && s_ready) quat_results_due.push_back(predict_quat(s_data));
            if (m_valid && m_ready) begin
                if (quat_results_due.size() == 0) begin
                    $error("result transaction with nothing expected: %p", m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    want = quat_results_due.pop_front();
                    if (want != m_data) begin
                        fail_count <= fail_count + 1;
                        if (want.r_x != m_data.r_x)
                            $error("r_x expected %0d got %0d", want.r_x, m_data.r_x);
                        if (want.r_y != m_data.r_y)
                            $error("r_y expected %0d got %0d", want.r_y, m_data.r_y);
                        if (want.r_z != m_data.r_z)
                            $error("r_z expected %0d got %0d", want.r_z, m_data.r_z);
                        if (want.r_w != m_data.r_w)
                            $error("r_w expected %0d got %0d", want.r_w, m_data.r_w);
                        if (want.magnitude != m_data.magnitude)
                            $error("magnitude expected %0d got %0d",
                                   want.magnitude, m_data.magnitude);
                        if (want.zero_length != m_data.zero_length)
                            $error("zero_length expected %0d got %0d",
                                   want.zero_length, m_data.zero_length);
                        if (want.saturated != m_data.saturated)
                            $error("saturated expected %0d got %0d",
                                   want.saturated, m_data.saturated);
                    end
                end
            end
        end
    end

endmodule

FILE: dv/quaternion_arithmetic_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit_tb
// Drives directed corner quaternions and then random ones through the unit,
// with random gaps on both channels, a long result back-pressure stretch and
// a full drain pause; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit_tb;

    localparam int CW           = qau_pkg::CW;
    localparam int RANDOM_ITEMS = 500;
    localparam int PIPE_DEPTH   = 60;
    localparam int HOLD_CYCLES  = 4 * PIPE_DEPTH;
    localparam int CYCLE_LIMIT  = 200000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    qau_pkg::in_item_t  s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    qau_pkg::out_item_t m_data;
    int                 fail_count;
    int                 pending_count;
    int                 cycle_count = 0;
    bit                 hold_request = 1'b0;
    bit                 stimulus_done = 1'b0;

    always #5 aclk = ~aclk;

    quaternion_arithmetic_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    quaternion_arithmetic_unit_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    // Mostly short gaps, now and then a long one, often none at all.
    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Pick a component: extremes often so saturation paths get exercised.
    function automatic logic signed [CW-1:0] pick_comp();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh4000;
            3: return 16'shC000;
            4: return CW'($urandom_range(0, 3) - 2);
            default: return CW'($urandom_range(0, 65535));
        endcase
    endfunction

    // Present one transaction and hold it until accepted.
    task automatic send_quat(input qau_pkg::in_item_t t);
        s_valid <= 1'b1;
        s_data  <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Idle the input after a transaction, for the given number of cycles.
    task automatic idle_input(input int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic send_directed(input logic [2:0] op, input logic signed [CW-1:0] ax,
                                 input logic signed [CW-1:0] ay, input logic signed [CW-1:0] az,
                                 input logic signed [CW-1:0] aw, input logic signed [CW-1:0] bx,
                                 input logic signed [CW-1:0] by, input logic signed [CW-1:0] bz,
                                 input logic signed [CW-1:0] bw);
        qau_pkg::in_item_t t;
        t = '{op, ax, ay, az, aw, bx, by, bz, bw};
        send_quat(t);
        idle_input(gap_length());
    endtask

    // Result side: random stalls, plus one long hold-off counted here.
    always @(posedge aclk) begin
        int stall_left;
        int hold_left;
        bit hold_taken;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
            hold_taken = 1'b0;
        end else if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!stimulus_done) stall_left = gap_length();
        end
    end

    // Bound the run: hang on a stuck handshake becomes a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("quaternion_arithmetic_unit test failed");
            $finish;
        end
    end

    initial begin
        qau_pkg::in_item_t t;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed corners: every op, extremes, saturation, zero length, unused ops.
        send_directed(qau_pkg::OP_PRODUCT, 16'sh4000, 0, 0, 0, 0, 16'sh4000, 0, 0);
        send_directed(qau_pkg::OP_PRODUCT, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                      16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_directed(qau_pkg::OP_PRODUCT, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                      16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_directed(qau_pkg::OP_PRODUCT, 1, 0, 0, 0, 0, 0, 0, 16'sh2000);
        send_directed(qau_pkg::OP_PRODUCT, -1, 0, 0, 0, 0, 0, 0, 16'sh2000);
        send_directed(qau_pkg::OP_VECTOR, 16'sh1234, -16'sh0567, 16'sh2000, 16'sh4000,
                      16'sh4000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
        send_directed(qau_pkg::OP_CONJUGATE, 16'sh8000, 16'sh7FFF, 0, 16'sh8000,
                      0, 0, 0, 0);
        send_directed(qau_pkg::OP_CONJUGATE, 1, -1, 16'sh8000, 16'sh7FFF, 0, 0, 0, 0);
        send_directed(qau_pkg::OP_NORMALIZE, 0, 0, 0, 0, 5, 5, 5, 5);
        send_directed(qau_pkg::OP_NORMALIZE, 1, 0, 0, 0, 0, 0, 0, 0);
        send_directed(qau_pkg::OP_NORMALIZE, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                      0, 0, 0, 0);
        send_directed(qau_pkg::OP_NORMALIZE, 16'sh7FFF, 0, 0, 0, 0, 0, 0, 0);
        send_directed(qau_pkg::OP_NORMALIZE, 3, -4, 0, 0, 0, 0, 0, 0);
        send_directed(qau_pkg::OP_LENGTH, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                      0, 0, 0, 0);
        send_directed(qau_pkg::OP_LENGTH, 0, 0, 0, 0, 0, 0, 0, 0);
        send_directed(qau_pkg::OP_LENGTH, 1, 1, 0, 0, -1, -1, -1, -1);
        for (int c = 5; c <= 7; c++)
            send_directed(c[2:0], 16'sh7FFF, 1, 2, 3, 4, 5, 6, 7);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Hold results off for a long stretch so the pipe fills and stalls.
            if (n == 150) hold_request = 1'b1;
            // Pause the input until every result is back.
            if (n == 350) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                while (pending_count != 0) @(posedge aclk);
            end
            t.op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                 : 3'($urandom_range(0, 4));
            t.a_x = pick_comp(); t.a_y = pick_comp(); t.a_z = pick_comp(); t.a_w = pick_comp();
            t.b_x = pick_comp(); t.b_y = pick_comp(); t.b_z = pick_comp(); t.b_w = pick_comp();
            send_quat(t);
            // Long unbroken bursts at the start of the random part.
            if (n > 40) idle_input(gap_length());
        end
        s_valid <= 1'b0;
        stimulus_done = 1'b1;

        while (pending_count != 0) @(posedge aclk);
        repeat (PIPE_DEPTH) @(posedge aclk);
        if (fail_count == 0) begin
            $display("quaternion_arithmetic_unit test passed");
        end else begin
            $display("quaternion_arithmetic_unit test failed");
        end
        $finish;
    end

endmodule
